// ----- rtl/core/wer_pkg.sv -----
// Shared types and constants for the whitened entropy range generator.
// Used by every module under rtl/core but wer_vn_whitener; it depends on nothing else.
`default_nettype none

package wer_pkg;

    // Field and bus widths.
    localparam int SAMPLE_BITS = 10;
    localparam int UUID_BYTES  = 16;
    localparam int VALUE_W     = 32;
    localparam int IDX_W       = 4;
    localparam int MODE_W      = 3;
    localparam int REM_W       = 6;
    localparam int SHIFT_W     = 5;
    localparam int SETTLE_W    = 2;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((VALUE_W + IDX_W + 7) / 8) * 8;
    localparam int M_PAD_W     = M_TDATA_W - VALUE_W - IDX_W;

    // Output modes.
    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_BIT    = 3'd0;
    localparam mode_t MODE_BYTE   = 3'd1;
    localparam mode_t MODE_WORD15 = 3'd2;
    localparam mode_t MODE_WORD31 = 3'd3;
    localparam mode_t MODE_RANGED = 3'd4;
    localparam mode_t MODE_UUID   = 3'd5;

    // Register indexes, taken from paddr[3:2].
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_MODE = 2'd0;
    localparam reg_idx_t REG_LOW  = 2'd1;
    localparam reg_idx_t REG_HIGH = 2'd2;

    // Bits drawn per value in the fixed modes.
    localparam logic [REM_W-1:0] WIDTH_BIT    = 6'd1;
    localparam logic [REM_W-1:0] WIDTH_BYTE   = 6'd8;
    localparam logic [REM_W-1:0] WIDTH_WORD15 = 6'd15;
    localparam logic [REM_W-1:0] WIDTH_WORD31 = 6'd31;

    // UUID version and variant forcing.
    localparam logic [IDX_W-1:0] UUID_VERSION_POS  = 4'd6;
    localparam logic [IDX_W-1:0] UUID_VARIANT_POS  = 4'd8;
    localparam logic [IDX_W-1:0] UUID_LAST_POS     = IDX_W'(UUID_BYTES - 1);
    localparam logic [7:0]       UUID_VERSION_SET  = 8'h40;
    localparam logic [7:0]       UUID_VERSION_KEEP = 8'h0F;
    localparam logic [7:0]       UUID_VARIANT_SET  = 8'h80;
    localparam logic [7:0]       UUID_VARIANT_KEEP = 8'h3F;

    // Configuration as seen by the datapath, including derived range terms.
    typedef struct packed {
        mode_t              mode;
        logic [VALUE_W-1:0] range_low;
        logic [VALUE_W-1:0] span;
        logic [REM_W-1:0]   range_width;
        logic               empty;
        logic               busy;
        logic               clear;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   byte_index;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/wer_apb_regs.sv -----
// Configuration registers on an APB-style port, plus the registered span and width terms.
// Depends on wer_pkg.
`default_nettype none

module wer_apb_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wer_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [wer_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [wer_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    output wer_pkg::cfg_t                      cfg
);
    import wer_pkg::*;

    reg_idx_t             reg_idx;
    logic                 wr_en;
    logic                 wr_hit;
    mode_t                mode_reg;
    logic [VALUE_W-1:0]   low_reg;
    logic [VALUE_W-1:0]   high_reg;
    logic [VALUE_W-1:0]   span_reg;
    logic                 empty_reg;
    logic [REM_W-1:0]     width_reg;
    logic [SETTLE_W-1:0]  settle_reg;
    logic [SETTLE_W-1:0]  settle_next;
    logic [VALUE_W-1:0]   diff;
    logic [VALUE_W-1:0]   span_dec;
    logic [REM_W-1:0]     span_len;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_hit  = wr_en && (reg_idx == REG_MODE || reg_idx == REG_LOW ||
                               reg_idx == REG_HIGH);

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_BYTE;
            low_reg  <= '0;
            high_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE: mode_reg <= pwdata[MODE_W-1:0];
                REG_LOW:  low_reg  <= pwdata;
                REG_HIGH: high_reg <= pwdata;
                default:  ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            REG_MODE: prdata = {{(APB_DATA_W-MODE_W){1'b0}}, mode_reg};
            REG_LOW:  prdata = low_reg;
            REG_HIGH: prdata = high_reg;
            default:  prdata = '0;
        endcase
    end

    // First stage: span modulo 2^32 and the empty-or-unit test.
    assign diff = high_reg - low_reg;

    always_ff @(posedge aclk) begin
        span_reg  <= diff;
        empty_reg <= ($signed(low_reg) >= $signed(high_reg)) || (diff == VALUE_W'(1));
    end

    // Second stage: bits per ranged value, one fewer for a power-of-two span.
    assign span_dec = span_reg - VALUE_W'(1);

    always_comb begin
        span_len = '0;
        for (int i = 0; i < VALUE_W; i++) begin
            if (span_reg[i]) begin
                span_len = REM_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((span_reg & span_dec) == '0) begin
            width_reg <= span_len - REM_W'(1);
        end else begin
            width_reg <= span_len;
        end
    end

    // Busy holds while the span and width registers follow a write or a reset.
    always_comb begin
        if (wr_hit) begin
            settle_next = SETTLE_W'(2);
        end else if (settle_reg != '0) begin
            settle_next = settle_reg - SETTLE_W'(1);
        end else begin
            settle_next = settle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_W'(2);
        end else begin
            settle_reg <= settle_next;
        end
    end

    assign cfg.mode        = mode_reg;
    assign cfg.range_low   = low_reg;
    assign cfg.span        = span_reg;
    assign cfg.range_width = width_reg;
    assign cfg.empty       = empty_reg;
    assign cfg.busy        = (settle_reg != '0);
    assign cfg.clear       = wr_hit;

endmodule

`default_nettype wire

// ----- rtl/core/wer_vn_whitener.sv -----
// Two cascaded von Neumann stages that whiten the raw entropy bit.
// Does not depend on wer_pkg; no types are needed.
`default_nettype none

module wer_vn_whitener (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic step,
    input  wire logic raw,
    output logic      pass,
    output logic      wb
);
    logic s1_held_reg;
    logic s1_bit_reg;
    logic s2_held_reg;
    logic s2_bit_reg;
    logic pass1;

    // An unequal pair passes its second bit, which is the present bit in both stages.
    assign pass1 = s1_held_reg && (s1_bit_reg != raw);
    assign pass  = pass1 && s2_held_reg && (s2_bit_reg != raw);
    assign wb    = raw;

    // Pair state of both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_held_reg <= 1'b0;
            s1_bit_reg  <= 1'b0;
            s2_held_reg <= 1'b0;
            s2_bit_reg  <= 1'b0;
        end else if (step) begin
            s1_held_reg <= !s1_held_reg;
            if (!s1_held_reg) begin
                s1_bit_reg <= raw;
            end
            if (pass1) begin
                s2_held_reg <= !s2_held_reg;
                if (!s2_held_reg) begin
                    s2_bit_reg <= raw;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/wer_assembler.sv -----
// Fills values MSB first from whitened bits, applies range rejection and UUID formatting.
// Depends on wer_pkg.
`default_nettype none

module wer_assembler (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wer_pkg::cfg_t         cfg,
    input  wire logic             step,
    input  wire logic             wb,
    output logic                  res_valid,
    output wer_pkg::result_t      res
);
    import wer_pkg::*;

    logic [VALUE_W-1:0] acc_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [REM_W-1:0]   width_sel;
    logic [REM_W-1:0]   rem0;
    logic [REM_W-1:0]   rem1;
    logic [VALUE_W-1:0] acc0;
    logic [VALUE_W-1:0] acc1;
    logic               reject;
    logic               done;
    logic [7:0]         byte_raw;
    logic [7:0]         byte_out;

    // Bits per value for the current mode; the unused codes behave as bytes.
    always_comb begin
        unique case (cfg.mode)
            MODE_BIT:    width_sel = WIDTH_BIT;
            MODE_WORD15: width_sel = WIDTH_WORD15;
            MODE_WORD31: width_sel = WIDTH_WORD31;
            MODE_RANGED: width_sel = cfg.range_width;
            default:     width_sel = WIDTH_BYTE;
        endcase
    end

    // Place the new bit and test the prefix against the span.
    assign rem0   = (rem_reg == '0) ? width_sel : rem_reg;
    assign acc0   = (rem_reg == '0) ? '0 : acc_reg;
    assign rem1   = rem0 - REM_W'(1);
    assign acc1   = acc0 | (VALUE_W'(wb) << rem1[SHIFT_W-1:0]);
    assign reject = (cfg.mode == MODE_RANGED) && (acc1 >= cfg.span);
    assign done   = !reject && (rem1 == '0);

    // Accumulator, fill count and UUID byte position.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.clear) begin
            acc_reg <= '0;
            rem_reg <= '0;
            pos_reg <= '0;
        end else if (step) begin
            if (reject) begin
                acc_reg <= '0;
                rem_reg <= width_sel;
            end else if (!done) begin
                acc_reg <= acc1;
                rem_reg <= rem1;
            end else begin
                acc_reg <= '0;
                rem_reg <= '0;
                if (cfg.mode == MODE_UUID) begin
                    pos_reg <= (pos_reg == UUID_LAST_POS) ? '0 : pos_reg + IDX_W'(1);
                end
            end
        end
    end

    // UUID byte with version and variant bits forced.
    assign byte_raw = acc1[7:0];

    always_comb begin
        if (pos_reg == UUID_VERSION_POS) begin
            byte_out = UUID_VERSION_SET | (UUID_VERSION_KEEP & byte_raw);
        end else if (pos_reg == UUID_VARIANT_POS) begin
            byte_out = UUID_VARIANT_SET | (UUID_VARIANT_KEEP & byte_raw);
        end else begin
            byte_out = byte_raw;
        end
    end

    // Result formatting.
    always_comb begin
        res.byte_index = '0;
        res.last       = 1'b1;
        if (cfg.mode == MODE_RANGED) begin
            res.value = cfg.range_low + acc1;
        end else if (cfg.mode == MODE_UUID) begin
            res.value      = {{(VALUE_W-8){1'b0}}, byte_out};
            res.byte_index = pos_reg;
            res.last       = (pos_reg == UUID_LAST_POS);
        end else begin
            res.value = acc1;
        end
    end

    assign res_valid = step && done;

endmodule

`default_nettype wire

// ----- rtl/core/whitened_entropy_range_generator.sv -----
// A sample beat moves from the input register to the result register; throughput is one sample
// beat per cycle unless stalled, and a result needs at least four raw bits per whitened bit.
// An empty or unit range returns range_low for every sample beat, one result per beat.
// Reset is synchronous and active low; it and every write to a mapped register hold s_tready
// low while the span and width registers recompute. Whitener state survives writes.
`default_nettype none

module whitened_entropy_range_generator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Sample beats.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [wer_pkg::S_TDATA_W-1:0] s_tdata,  // [9:0] sample
    // Result beats.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [wer_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] value, [35:32] byte_index
    output logic                               m_tlast,
    // Configuration.
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wer_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [wer_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [wer_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready
);
    import wer_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    in_valid_reg;
    logic    in_bit_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;
    logic    proc;
    logic    bypass;
    logic    wh_pass;
    logic    wh_bit;
    logic    s_accept;

    wer_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline control: the result register frees when it is empty or being taken.
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !cfg.busy && (!in_valid_reg || advance);
    assign s_accept = s_tvalid && s_tready;
    assign bypass   = (cfg.mode == MODE_RANGED) && cfg.empty;

    // Input register holds the raw entropy bit of the sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_bit_reg <= s_tdata[0];
        end
    end

    wer_vn_whitener u_whitener (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (proc && !bypass),
        .raw     (in_bit_reg),
        .pass    (wh_pass),
        .wb      (wh_bit)
    );

    wer_assembler u_assembler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (proc && !bypass && wh_pass),
        .wb        (wh_bit),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= proc && (bypass || res_valid);
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            if (bypass) begin
                out_reg.value      <= cfg.range_low;
                out_reg.byte_index <= '0;
                out_reg.last       <= 1'b1;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_reg.byte_index, out_reg.value};
    assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
    // No sample is taken while the range terms are recomputing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.busy |-> !s_tready)
        else $error("sample accepted while configuration settles");

    // A pending sample stays in the input register while the result side stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("input register dropped a stalled sample");

    // A nonzero byte index only comes from a UUID byte, which is last only at the end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.byte_index != '0) |->
            (out_reg.last == (out_reg.byte_index == UUID_LAST_POS)))
        else $error("UUID byte index and last flag disagree");
`endif

endmodule

`default_nettype wire

// ----- verif/whitened_entropy_range_generator_tb.sv -----
// Self-checking testbench for the whitened entropy range generator.
// It drives sample beats and APB register writes, predicts every result beat
// and checks it field by field. It needs only the RTL and wer_pkg.
`timescale 1ns / 100ps

module whitened_entropy_range_generator_tb;
    import wer_pkg::*;

    // Mode codes that the package leaves unnamed; they act as the byte mode.
    localparam mode_t    MODE_SPARE6  = 3'd6;
    localparam mode_t    MODE_SPARE7  = 3'd7;
    // Register slot past the end of the register list.
    localparam reg_idx_t REG_UNMAPPED = 2'd3;
    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // Expected result beats, oldest first.
    result_t due_values[$];
    int faults = 0;
    bit no_gaps = 1'b0;

    // Predicted register contents.
    mode_t       cfg_mode = MODE_BYTE;
    logic [31:0] cfg_low = '0;
    logic [31:0] cfg_high = '0;

    // Predicted whitener and value assembly state.
    logic        pair1_open = 1'b0;
    logic        pair1_bit = 1'b0;
    logic        pair2_open = 1'b0;
    logic        pair2_bit = 1'b0;
    logic [31:0] draw_acc = '0;
    int unsigned bits_left = 0;
    logic [3:0]  uuid_pos = '0;

    whitened_entropy_range_generator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Number of significant bits in a span.
    function automatic int unsigned span_bits(logic [31:0] x);
        int unsigned n;
        n = 0;
        while (x != 0) begin
            n++;
            x >>= 1;
        end
        return n;
    endfunction

    // Bits that a fresh value takes in the current mode.
    function automatic int unsigned draw_width(logic [31:0] span);
        case (cfg_mode)
            MODE_BIT:    return 1;
            MODE_WORD15: return 15;
            MODE_WORD31: return 31;
            MODE_RANGED: begin
                if ((span & (span - 1)) == 0) return span_bits(span) - 1;
                return span_bits(span);
            end
            default:     return 8;
        endcase
    endfunction

    // Runs one accepted sample through the predicted whitener and queues any value it completes.
    task automatic whiten_sample(input logic [SAMPLE_BITS-1:0] smp);
        logic [31:0] span;
        logic        mid;
        logic        wb;
        logic [31:0] v;
        result_t     r;
        span = 32'd2;
        r.byte_index = '0;
        r.last = 1'b1;
        // An empty or unit range answers every beat with the low bound.
        if (cfg_mode == MODE_RANGED) begin
            span = ($signed(cfg_low) >= $signed(cfg_high)) ? 32'd0 : cfg_high - cfg_low;
            if (span <= 1) begin
                r.value = cfg_low;
                due_values.push_back(r);
                return;
            end
        end
        // First von Neumann stage.
        if (!pair1_open) begin
            pair1_open = 1'b1;
            pair1_bit = smp[0];
            return;
        end
        pair1_open = 1'b0;
        if (pair1_bit == smp[0]) return;
        mid = smp[0];
        // Second von Neumann stage.
        if (!pair2_open) begin
            pair2_open = 1'b1;
            pair2_bit = mid;
            return;
        end
        pair2_open = 1'b0;
        if (pair2_bit == mid) return;
        wb = mid;
        // Fill the value from the top bit down.
        if (bits_left == 0) begin
            draw_acc = '0;
            bits_left = draw_width(span);
        end
        bits_left--;
        if (wb) draw_acc[bits_left] = 1'b1;
        // Prefix rejection restarts the value once it cannot fall inside the span.
        if (cfg_mode == MODE_RANGED && draw_acc >= span) begin
            draw_acc = '0;
            bits_left = draw_width(span);
            return;
        end
        if (bits_left != 0) return;
        v = draw_acc;
        draw_acc = '0;
        if (cfg_mode == MODE_RANGED) begin
            r.value = cfg_low + v;
        end else if (cfg_mode == MODE_UUID) begin
            v = v & 32'hFF;
            if (uuid_pos == UUID_VERSION_POS)
                v = {24'd0, UUID_VERSION_SET | (UUID_VERSION_KEEP & v[7:0])};
            else if (uuid_pos == UUID_VARIANT_POS)
                v = {24'd0, UUID_VARIANT_SET | (UUID_VARIANT_KEEP & v[7:0])};
            r.value = v;
            r.byte_index = uuid_pos;
            r.last = (uuid_pos == UUID_LAST_POS);
            uuid_pos = (uuid_pos == UUID_LAST_POS) ? 4'd0 : uuid_pos + 4'd1;
        end else begin
            r.value = v;
        end
        due_values.push_back(r);
    endtask

    // Sends one sample beat, with random gaps before it unless gaps are off.
    task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp);
        @(negedge aclk);
        while (!no_gaps && $urandom_range(99) < 9) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {{(S_TDATA_W - SAMPLE_BITS){1'b0}}, smp};
        do @(posedge aclk); while (!s_tready);
        whiten_sample(smp);
    endtask

    // Four raw bits that whiten to the given bit when both stages start empty.
    task automatic send_whitened_bit(input logic w);
        send_sample({9'($urandom), w});
        send_sample({9'($urandom), ~w});
        send_sample({9'($urandom), ~w});
        send_sample({9'($urandom), w});
    endtask

    // Closes any open pair in both stages, so that each following quad yields one bit.
    task automatic align_whitener();
        if (pair1_open) send_sample(10'($urandom));
        if (pair2_open) begin
            send_sample({9'($urandom), 1'b0});
            send_sample({9'($urandom), 1'b1});
        end
    endtask

    // Stops sending and waits until every result has arrived and the pipeline is quiet.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (due_values.size() != 0) @(posedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
        drain_results();
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        // A write to a listed register abandons the value in progress.
        if (idx == REG_MODE || idx == REG_LOW || idx == REG_HIGH) begin
            case (idx)
                REG_MODE: cfg_mode = data[MODE_W-1:0];
                REG_LOW:  cfg_low = data;
                default:  cfg_high = data;
            endcase
            draw_acc = '0;
            bits_left = 0;
            uuid_pos = '0;
        end
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Sets all three registers; the mode word carries junk above its field.
    task automatic set_config(input mode_t m, input logic [31:0] lo, input logic [31:0] hi);
        write_reg(REG_LOW, lo);
        write_reg(REG_HIGH, hi);
        write_reg(REG_MODE, {29'($urandom), m});
    endtask

    // Mostly well-formed whitening quads, with single noisy beats and equal-bit pairs mixed in.
    task automatic stream_phase(input int count);
        int n;
        int pick;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(99);
            if (pick < 80) begin
                send_whitened_bit(1'($urandom));
                n += 4;
            end else if (pick < 90) begin
                send_sample(10'($urandom));
                n++;
            end else begin
                pick = $urandom_range(1);
                send_sample({9'($urandom), 1'(pick)});
                send_sample({9'($urandom), 1'(pick)});
                n += 2;
            end
        end
    endtask

    // Result side: random back-pressure.
    always @(negedge aclk) begin
        m_tready = no_gaps || ($urandom_range(99) >= 9);
    end

    // Compare every result beat against the oldest prediction.
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_values.size() == 0) begin
                $display("%0t: unexpected result beat, value %h index %0d last %b",
                         $time, m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: IDX_W], m_tlast);
                faults++;
            end else begin
                exp_r = due_values.pop_front();
                if (m_tdata[VALUE_W-1:0] !== exp_r.value) begin
                    $display("%0t: value expected %h got %h",
                             $time, exp_r.value, m_tdata[VALUE_W-1:0]);
                    faults++;
                end
                if (m_tdata[VALUE_W +: IDX_W] !== exp_r.byte_index) begin
                    $display("%0t: byte_index expected %0d got %0d",
                             $time, exp_r.byte_index, m_tdata[VALUE_W +: IDX_W]);
                    faults++;
                end
                if (m_tlast !== exp_r.last) begin
                    $display("%0t: last expected %b got %b", $time, exp_r.last, m_tlast);
                    faults++;
                end
            end
        end
    end

    // Equal raw pairs are dropped; the sample extremes feed the whitener in byte mode.
    task automatic test_sample_extremes();
        send_sample(10'd0);
        send_sample(10'd0);
        send_sample(10'd1023);
        send_sample(10'd1023);
        send_sample(10'd0);
        send_sample(10'd1023);
    endtask

    // One whitened bit per value in bit mode.
    task automatic test_single_bits();
        set_config(MODE_BIT, '0, '0);
        send_whitened_bit(1'b1);
        send_whitened_bit(1'b0);
    endtask

    // Empty, unit and inverted ranges return the low bound for every beat.
    task automatic test_degenerate_ranges();
        set_config(MODE_RANGED, 32'd5, 32'd5);
        send_sample(10'($urandom));
        send_sample(10'($urandom));
        write_reg(REG_HIGH, 32'd6);
        send_sample(10'($urandom));
        send_sample(10'($urandom));
        set_config(MODE_RANGED, INT_MAX, INT_MIN);
        send_sample(10'($urandom));
    endtask

    // A span of two draws a single bit above a negative low bound.
    task automatic test_span_two();
        set_config(MODE_RANGED, 32'hFFFF_FFFF, 32'd1);
        send_whitened_bit(1'b1);
    endtask

    // A write past the register list leaves the value in progress alone.
    task automatic test_unmapped_write();
        set_config(MODE_BIT, '0, '0);
        send_sample(10'd1);
        send_sample(10'd0);
        write_reg(REG_UNMAPPED, 32'($urandom));
        send_sample(10'd0);
        send_sample(10'd1);
    endtask

    // Byte mode with both sides streaming without any gap.
    task automatic test_steady_stream();
        set_config(MODE_BYTE, '0, '0);
        no_gaps = 1'b1;
        stream_phase(120);
        no_gaps = 1'b0;
    endtask

    // The bit and word modes, and the unused codes that act as bytes.
    task automatic test_fixed_modes();
        set_config(MODE_BIT, 32'($urandom), 32'($urandom));
        stream_phase(60);
        set_config(MODE_WORD15, '0, '0);
        stream_phase(60);
        set_config(MODE_WORD31, '0, '0);
        stream_phase(150);
        set_config(MODE_SPARE6, '0, '0);
        stream_phase(60);
        set_config(MODE_SPARE7, '0, '0);
        stream_phase(60);
    endtask

    // Ranged draws: rejection, power-of-two spans, the widest signed span and random bounds.
    task automatic test_ranged_draws();
        set_config(MODE_RANGED, -32'sd7, 32'sd93);
        stream_phase(80);
        set_config(MODE_RANGED, 32'd0, 32'd256);
        stream_phase(60);
        set_config(MODE_RANGED, 32'hC000_0000, 32'h4000_0000);
        stream_phase(80);
        set_config(MODE_RANGED, INT_MIN, INT_MAX);
        stream_phase(120);
        set_config(MODE_RANGED, 32'($urandom), 32'($urandom));
        stream_phase(60);
    endtask

    // UUID bytes for more than sixteen positions, so the byte position wraps.
    task automatic test_uuid_bytes();
        set_config(MODE_UUID, '0, '0);
        align_whitener();
        repeat (144) send_whitened_bit(1'($urandom));
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        test_sample_extremes();
        test_single_bits();
        test_degenerate_ranges();
        test_span_two();
        test_unmapped_write();
        test_steady_stream();
        test_fixed_modes();
        test_ranged_draws();
        test_uuid_bytes();
        drain_results();
        repeat (10) @(posedge aclk);
        if (faults == 0) begin
            $display("whitened_entropy_range_generator: match");
        end else begin
            $display("whitened_entropy_range_generator: mismatch");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("whitened_entropy_range_generator: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/wer_pkg.sv
rtl/core/wer_apb_regs.sv
rtl/core/wer_vn_whitener.sv
rtl/core/wer_assembler.sv
rtl/core/whitened_entropy_range_generator.sv
verif/whitened_entropy_range_generator_tb.sv
